// File: rtl/usmg_pkg.sv
// ----------------------------------------------------------------------------
// usmg_pkg
// Shared types, codes and the quarter-wave sine table for the UV sphere
// mesh generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package usmg_pkg;

  localparam int SINE_TABLE_DEPTH = 256;
  localparam int CFG_INDEX_BITS   = 2;
  localparam int CFG_DATA_BITS    = 16;
  localparam int COUNT_BITS       = 9;
  localparam int INDEX_BITS       = 17;

  localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;

  localparam logic [63:0] TAYLOR_DEN [1:23] = '{
    64'd6,    64'd20,   64'd42,   64'd72,   64'd110,  64'd156,  64'd210,  64'd272,
    64'd342,  64'd420,  64'd506,  64'd600,  64'd702,  64'd812,  64'd930,  64'd1056,
    64'd1190, 64'd1332, 64'd1482, 64'd1640, 64'd1806, 64'd1980, 64'd2162
  };

  localparam logic signed [15:0] NORM_TOP    = 16'sh7FFF;
  localparam logic signed [15:0] NORM_BOTTOM = 16'sh8000;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_INDEX  = 1'b1;

  typedef enum logic [1:0] {
    CFG_STACK_COUNT,
    CFG_SLICE_COUNT,
    CFG_LATITUDE_STEP,
    CFG_LONGITUDE_STEP
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_TOP,
    PH_RINGS,
    PH_BOTTOM,
    PH_TOPFAN,
    PH_MID,
    PH_BOTFAN,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    REC_TOP,
    REC_RING,
    REC_BOTTOM,
    REC_INDEX
  } rec_kind_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] stacks;
    logic [COUNT_BITS-1:0] slices;
    logic [15:0]           lat_step;
    logic [15:0]           lon_step;
  } cfg_t;

  typedef struct packed {
    logic                  valid;
    rec_kind_t             rec;
    logic [INDEX_BITS-1:0] index;
    logic                  last;
  } cmd_t;

  typedef struct packed {
    logic                  kind;
    logic signed [15:0]    pos_x;
    logic signed [15:0]    pos_y;
    logic signed [15:0]    pos_z;
    logic signed [15:0]    norm_x;
    logic signed [15:0]    norm_y;
    logic signed [15:0]    norm_z;
    logic [INDEX_BITS-1:0] vertex_index;
    logic                  last;
  } rec_t;

  typedef logic [SINE_TABLE_DEPTH:0][15:0] sin_tab_t;

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t    tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q;
    logic        stop;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (HALFPI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      stop = 1'b0;
      for (int n = 1; n < 24; n++) begin
        if (!stop) begin
          if (term == 64'd0) begin
            stop = 1'b1;
          end else begin
            term = (term * x2) >> 30;
            term = term / TAYLOR_DEN[n];
            if ((n % 2) == 1) begin
              sum = sum - term;
            end else begin
              sum = sum + term;
            end
          end
        end
      end
      q = (sum + 64'd16384) >> 15;
      tab[k] = (q > 64'd32767) ? 16'h7FFF : q[15:0];
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

// File: rtl/usmg_if.sv
// ----------------------------------------------------------------------------
// usmg_if
// Valid/ready channels of the UV sphere mesh generator: step requests in,
// mesh records out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface usmg_step_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface usmg_mesh_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [15:0]                  pos_x;
  logic signed [15:0]                  pos_y;
  logic signed [15:0]                  pos_z;
  logic signed [15:0]                  norm_x;
  logic signed [15:0]                  norm_y;
  logic signed [15:0]                  norm_z;
  logic [usmg_pkg::INDEX_BITS-1:0]     vertex_index;
  logic                                last;

  modport source (
    output valid, output kind, output pos_x, output pos_y, output pos_z,
    output norm_x, output norm_y, output norm_z, output vertex_index, output last,
    input ready
  );
  modport sink (
    input valid, input kind, input pos_x, input pos_y, input pos_z,
    input norm_x, input norm_y, input norm_z, input vertex_index, input last,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/usmg_cfg.sv
// ----------------------------------------------------------------------------
// usmg_cfg
// Configuration registers with count clamping for the mesh sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usmg_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [usmg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [usmg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output usmg_pkg::cfg_t                      cfg
);

  logic [usmg_pkg::COUNT_BITS-1:0] stack_count;
  logic [usmg_pkg::COUNT_BITS-1:0] slice_count;
  logic [15:0]                     latitude_step;
  logic [15:0]                     longitude_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count    <= 9'd16;
      slice_count    <= 9'd16;
      latitude_step  <= 16'd2048;
      longitude_step <= 16'd4096;
    end else if (cfg_we) begin
      case (usmg_pkg::cfg_reg_t'(cfg_index))
        usmg_pkg::CFG_STACK_COUNT:    stack_count    <= cfg_data[8:0];
        usmg_pkg::CFG_SLICE_COUNT:    slice_count    <= cfg_data[8:0];
        usmg_pkg::CFG_LATITUDE_STEP:  latitude_step  <= cfg_data;
        usmg_pkg::CFG_LONGITUDE_STEP: longitude_step <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.stacks   = (stack_count < 9'd2) ? 9'd2 :
                   ((stack_count > 9'd256) ? 9'd256 : stack_count);
    cfg.slices   = (slice_count < 9'd3) ? 9'd3 :
                   ((slice_count > 9'd256) ? 9'd256 : slice_count);
    cfg.lat_step = latitude_step;
    cfg.lon_step = longitude_step;
  end

endmodule

`default_nettype wire

// File: rtl/usmg_seq.sv
// ----------------------------------------------------------------------------
// usmg_seq
// Mesh walk sequencer: phase, counters and angle accumulators, with a
// registered command per step for the vertex datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usmg_seq #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  usmg_pkg::cfg_t        cfg,
  input  logic                  accept,
  input  logic                  restart,
  input  logic                  take,
  output usmg_pkg::cmd_t        cmd,
  output logic [ANGLE_BITS-1:0] cmd_lat,
  output logic [ANGLE_BITS-1:0] cmd_lon
);

  localparam int CB = usmg_pkg::COUNT_BITS;
  localparam int IB = usmg_pkg::INDEX_BITS;

  usmg_pkg::phase_t phase;
  usmg_pkg::phase_t phase_next;
  logic [CB-1:0]         ring_counter;
  logic [CB-1:0]         ring_counter_next;
  logic [CB-1:0]         column_counter;
  logic [CB-1:0]         column_counter_next;
  logic [2:0]            corner_counter;
  logic [2:0]            corner_counter_next;
  logic [ANGLE_BITS-1:0] latitude_angle;
  logic [ANGLE_BITS-1:0] latitude_angle_next;
  logic [ANGLE_BITS-1:0] longitude_angle;
  logic [ANGLE_BITS-1:0] longitude_angle_next;
  logic [IB-1:0]         ring_base;
  logic [IB-1:0]         ring_base_next;

  usmg_pkg::phase_t      cur_phase;
  logic [CB-1:0]         cur_ring;
  logic [CB-1:0]         cur_col;
  logic [2:0]            cur_corner;
  logic [ANGLE_BITS-1:0] cur_lat;
  logic [ANGLE_BITS-1:0] cur_lon;
  logic [IB-1:0]         cur_base;

  logic [ANGLE_BITS-1:0] lat_step_s;
  logic [ANGLE_BITS-1:0] lon_step_s;
  logic [CB-1:0]         st;
  logic [CB-1:0]         sl;
  logic [CB-1:0]         rv;
  logic [CB:0]           col_inc;
  logic [CB:0]           ring_inc;
  logic [3:0]            corner_inc;
  logic [IB:0]           mid_a;
  logic [IB:0]           south;
  logic [IB:0]           bot_base;
  logic [IB:0]           idx_wide;
  logic [17:0]           south_prod;

  logic                  has_result;
  usmg_pkg::rec_kind_t   rec_next;
  logic                  last_next;

  logic                  cmd_valid;
  usmg_pkg::rec_kind_t   cmd_rec;
  logic [IB-1:0]         cmd_index;
  logic                  cmd_last;

  function automatic logic [ANGLE_BITS-1:0] scale_step(input logic [15:0] s);
    logic [ANGLE_BITS+15:0] w;
    w = ({{ANGLE_BITS{1'b0}}, s} << ANGLE_BITS) >> 16;
    return w[ANGLE_BITS-1:0];
  endfunction

  assign lat_step_s = scale_step(cfg.lat_step);
  assign lon_step_s = scale_step(cfg.lon_step);
  assign st         = cfg.stacks;
  assign sl         = cfg.slices;
  assign rv         = cfg.slices + 9'd1;

  assign cur_phase  = restart ? usmg_pkg::PH_TOP : phase;
  assign cur_ring   = restart ? '0 : ring_counter;
  assign cur_col    = restart ? '0 : column_counter;
  assign cur_corner = restart ? '0 : corner_counter;
  assign cur_lat    = restart ? '0 : latitude_angle;
  assign cur_lon    = restart ? '0 : longitude_angle;
  assign cur_base   = restart ? IB'(1) : ring_base;

  assign col_inc    = {1'b0, cur_col} + 10'd1;
  assign ring_inc   = {1'b0, cur_ring} + 10'd1;
  assign corner_inc = {1'b0, cur_corner} + 4'd1;
  assign mid_a      = {1'b0, cur_base} + (IB+1)'(cur_col);
  assign south_prod = 18'(st - 9'd1) * 18'(rv);
  assign south      = (IB+1)'(south_prod) + (IB+1)'(1);
  assign bot_base   = south - (IB+1)'(rv);

  always_comb begin
    phase_next           = cur_phase;
    ring_counter_next    = cur_ring;
    column_counter_next  = cur_col;
    corner_counter_next  = cur_corner;
    latitude_angle_next  = cur_lat;
    longitude_angle_next = cur_lon;
    ring_base_next       = cur_base;
    has_result           = 1'b1;
    rec_next             = usmg_pkg::REC_INDEX;
    idx_wide             = '0;
    last_next            = 1'b0;
    case (cur_phase)
      usmg_pkg::PH_TOP: begin
        rec_next             = usmg_pkg::REC_TOP;
        phase_next           = usmg_pkg::PH_RINGS;
        ring_counter_next    = CB'(1);
        column_counter_next  = '0;
        latitude_angle_next  = lat_step_s;
        longitude_angle_next = '0;
      end
      usmg_pkg::PH_RINGS: begin
        rec_next             = usmg_pkg::REC_RING;
        longitude_angle_next = cur_lon + lon_step_s;
        if (col_inc > {1'b0, sl}) begin
          column_counter_next  = '0;
          longitude_angle_next = '0;
          ring_counter_next    = ring_inc[CB-1:0];
          latitude_angle_next  = cur_lat + lat_step_s;
          if (ring_inc >= {1'b0, st}) begin
            phase_next = usmg_pkg::PH_BOTTOM;
          end
        end else begin
          column_counter_next = col_inc[CB-1:0];
        end
      end
      usmg_pkg::PH_BOTTOM: begin
        rec_next            = usmg_pkg::REC_BOTTOM;
        phase_next          = usmg_pkg::PH_TOPFAN;
        column_counter_next = CB'(1);
        corner_counter_next = '0;
      end
      usmg_pkg::PH_TOPFAN: begin
        if (cur_corner == 3'd0) begin
          idx_wide = '0;
        end else if (cur_corner == 3'd1) begin
          idx_wide = (IB+1)'(col_inc);
        end else begin
          idx_wide = (IB+1)'(cur_col);
        end
        if (corner_inc >= 4'd3) begin
          corner_counter_next = '0;
          if (col_inc > {1'b0, sl}) begin
            ring_counter_next   = '0;
            column_counter_next = '0;
            ring_base_next      = IB'(1);
            phase_next          = (st > 9'd2) ? usmg_pkg::PH_MID : usmg_pkg::PH_BOTFAN;
          end else begin
            column_counter_next = col_inc[CB-1:0];
          end
        end else begin
          corner_counter_next = corner_inc[2:0];
        end
      end
      usmg_pkg::PH_MID: begin
        case (cur_corner)
          3'd0:       idx_wide = mid_a;
          3'd1, 3'd4: idx_wide = mid_a + (IB+1)'(1);
          3'd2, 3'd3: idx_wide = mid_a + (IB+1)'(rv);
          default:    idx_wide = mid_a + (IB+1)'(rv) + (IB+1)'(1);
        endcase
        if (corner_inc >= 4'd6) begin
          corner_counter_next = '0;
          if (col_inc >= {1'b0, sl}) begin
            column_counter_next = '0;
            ring_base_next      = cur_base + IB'(rv);
            if (ring_inc >= {1'b0, st - 9'd2}) begin
              ring_counter_next = '0;
              phase_next        = usmg_pkg::PH_BOTFAN;
            end else begin
              ring_counter_next = ring_inc[CB-1:0];
            end
          end else begin
            column_counter_next = col_inc[CB-1:0];
          end
        end else begin
          corner_counter_next = corner_inc[2:0];
        end
      end
      usmg_pkg::PH_BOTFAN: begin
        if (cur_corner == 3'd0) begin
          idx_wide = south;
        end else if (cur_corner == 3'd1) begin
          idx_wide = bot_base + (IB+1)'(cur_col);
        end else begin
          idx_wide = bot_base + (IB+1)'(col_inc);
        end
        last_next = (cur_corner >= 3'd2) && (col_inc >= {1'b0, sl});
        if (corner_inc >= 4'd3) begin
          corner_counter_next = '0;
          column_counter_next = col_inc[CB-1:0];
          if (col_inc >= {1'b0, sl}) begin
            phase_next = usmg_pkg::PH_DONE;
          end
        end else begin
          corner_counter_next = corner_inc[2:0];
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= usmg_pkg::PH_TOP;
      ring_counter    <= '0;
      column_counter  <= '0;
      corner_counter  <= '0;
      latitude_angle  <= '0;
      longitude_angle <= '0;
      ring_base       <= IB'(1);
      cmd_valid       <= 1'b0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        ring_counter    <= ring_counter_next;
        column_counter  <= column_counter_next;
        corner_counter  <= corner_counter_next;
        latitude_angle  <= latitude_angle_next;
        longitude_angle <= longitude_angle_next;
        ring_base       <= ring_base_next;
        cmd_valid       <= has_result;
      end else if (take) begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_rec   <= rec_next;
      cmd_index <= idx_wide[IB-1:0];
      cmd_last  <= last_next;
      cmd_lat   <= cur_lat;
      cmd_lon   <= cur_lon;
    end
  end

  always_comb begin
    cmd.valid = cmd_valid;
    cmd.rec   = cmd_rec;
    cmd.index = cmd_index;
    cmd.last  = cmd_last;
  end

endmodule

`default_nettype wire

// File: rtl/usmg_shade.sv
// ----------------------------------------------------------------------------
// usmg_shade
// Vertex datapath: quarter-wave sine/cosine lookup, Q1.15 products and the
// registered output record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usmg_shade #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  usmg_pkg::cmd_t        cmd,
  input  logic [ANGLE_BITS-1:0] cmd_lat,
  input  logic [ANGLE_BITS-1:0] cmd_lon,
  input  logic                  load,
  output logic                  rec_valid,
  output usmg_pkg::rec_t        rec
);

  localparam int D  = usmg_pkg::SINE_TABLE_DEPTH;
  localparam int IW = $clog2(D + 1);
  localparam int RB = ANGLE_BITS - 2;
  localparam int PW = RB + IW + 1;

  localparam usmg_pkg::sin_tab_t SIN_TAB = usmg_pkg::build_sin_tab();
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << RB;

  logic signed [15:0] sin_phi;
  logic signed [15:0] cos_phi;
  logic signed [15:0] sin_theta;
  logic signed [15:0] cos_theta;
  logic signed [15:0] nx;
  logic signed [15:0] ny;
  logic signed [15:0] nz;
  usmg_pkg::rec_t     rec_next;

  function automatic logic signed [15:0] sin_lookup(input logic [ANGLE_BITS-1:0] a);
    logic [1:0]    quad;
    logic [RB-1:0] r;
    logic [PW-1:0] prod;
    logic [PW-1:0] shifted;
    logic [IW-1:0] idx;
    logic [IW-1:0] mirror;
    quad    = a[ANGLE_BITS-1 -: 2];
    r       = a[RB-1:0];
    prod    = PW'(r) * PW'(D) + (PW'(1) << (RB - 1));
    shifted = prod >> RB;
    idx     = (shifted > PW'(D)) ? IW'(D) : shifted[IW-1:0];
    mirror  = IW'(D) - idx;
    case (quad)
      2'd0:    return $signed(SIN_TAB[idx]);
      2'd1:    return $signed(SIN_TAB[mirror]);
      2'd2:    return -$signed(SIN_TAB[idx]);
      default: return -$signed(SIN_TAB[mirror]);
    endcase
  endfunction

  function automatic logic signed [15:0] mul_q15(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [31:0] p;
    logic signed [31:0] s;
    p = 32'(a) * 32'(b);
    s = (p + 32'sd16384) >>> 15;
    return s[15:0];
  endfunction

  assign sin_phi   = sin_lookup(cmd_lat);
  assign cos_phi   = sin_lookup(cmd_lat + QUARTER);
  assign sin_theta = sin_lookup(cmd_lon);
  assign cos_theta = sin_lookup(cmd_lon + QUARTER);

  always_comb begin
    nx = '0;
    ny = '0;
    nz = '0;
    case (cmd.rec)
      usmg_pkg::REC_TOP:    ny = usmg_pkg::NORM_TOP;
      usmg_pkg::REC_BOTTOM: ny = usmg_pkg::NORM_BOTTOM;
      usmg_pkg::REC_RING: begin
        nx = mul_q15(sin_phi, cos_theta);
        ny = cos_phi;
        nz = mul_q15(sin_phi, sin_theta);
      end
      default: ;
    endcase
  end

  always_comb begin
    rec_next = '0;
    if (cmd.rec == usmg_pkg::REC_INDEX) begin
      rec_next.kind         = usmg_pkg::KIND_INDEX;
      rec_next.vertex_index = cmd.index;
      rec_next.last         = cmd.last;
    end else begin
      rec_next.kind   = usmg_pkg::KIND_VERTEX;
      rec_next.norm_x = nx;
      rec_next.norm_y = ny;
      rec_next.norm_z = nz;
      rec_next.pos_x  = nx >>> 1;
      rec_next.pos_y  = ny >>> 1;
      rec_next.pos_z  = nz >>> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (load) begin
      rec_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && cmd.valid) begin
      rec <= rec_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/uv_sphere_mesh_generator_core.sv
// ----------------------------------------------------------------------------
// uv_sphere_mesh_generator_core
// UV sphere mesh generator, radius one half: vertices then triangle indices,
// one record per step transaction until the final index.
// ----------------------------------------------------------------------------
//  channel  | role   | transaction carries
//  ---------+--------+-------------------------------------------------------
//  step     | sink   | restart
//  mesh     | source | kind, pos_x/y/z, norm_x/y/z, vertex_index, last
//  cfg      | write  | cfg_index, cfg_data on cfg_we
//
//  One step transaction per cycle while step is ready; its record passes
//  through the sequencer command register, then the output register.
//  The sequencer next state is computed combinationally, so steps never wait
//  on each other. A step after the final index produces no record.
//  Synchronous reset clears all control state; no sweep after reset.
//  A stall on mesh holds the output register; step stays ready while the
//  command register is empty or can move on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uv_sphere_mesh_generator_core #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [usmg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [usmg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  usmg_step_if.sink                           step,
  usmg_mesh_if.source                         mesh
);

  usmg_pkg::cfg_t        cfg;
  usmg_pkg::cmd_t        cmd;
  usmg_pkg::rec_t        rec;
  logic [ANGLE_BITS-1:0] cmd_lat;
  logic [ANGLE_BITS-1:0] cmd_lon;
  logic                  rec_valid;
  logic                  out_free;
  logic                  take;
  logic                  accept;

  assign out_free   = !rec_valid || mesh.ready;
  assign take       = cmd.valid && out_free;
  assign step.ready = !cmd.valid || out_free;
  assign accept     = step.valid && step.ready;

  usmg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  usmg_seq #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .restart (step.restart),
    .take    (take),
    .cmd     (cmd),
    .cmd_lat (cmd_lat),
    .cmd_lon (cmd_lon)
  );

  usmg_shade #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_shade (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_lat   (cmd_lat),
    .cmd_lon   (cmd_lon),
    .load      (out_free),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  assign mesh.valid        = rec_valid;
  assign mesh.kind         = rec.kind;
  assign mesh.pos_x        = rec.pos_x;
  assign mesh.pos_y        = rec.pos_y;
  assign mesh.pos_z        = rec.pos_z;
  assign mesh.norm_x       = rec.norm_x;
  assign mesh.norm_y       = rec.norm_y;
  assign mesh.norm_z       = rec.norm_z;
  assign mesh.vertex_index = rec.vertex_index;
  assign mesh.last         = rec.last;

endmodule

`default_nettype wire

// File: rtl/usmg_checker.sv
// ----------------------------------------------------------------------------
// usmg_checker
// Port-level checks on the mesh record channel of the generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usmg_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            mesh_valid,
  input logic                            mesh_ready,
  input logic                            kind,
  input logic signed [15:0]              pos_x,
  input logic signed [15:0]              pos_y,
  input logic signed [15:0]              pos_z,
  input logic signed [15:0]              norm_x,
  input logic signed [15:0]              norm_y,
  input logic signed [15:0]              norm_z,
  input logic [usmg_pkg::INDEX_BITS-1:0] vertex_index,
  input logic                            last
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    mesh_valid && !mesh_ready |=> mesh_valid && $stable(kind) && $stable(norm_x)
      && $stable(norm_y) && $stable(norm_z) && $stable(vertex_index) && $stable(last))
    else $error("mesh record changed while stalled");

  a_vertex_pos: assert property (@(posedge clk) disable iff (rst)
    mesh_valid && kind == usmg_pkg::KIND_VERTEX |->
      pos_x == (norm_x >>> 1) && pos_y == (norm_y >>> 1) && pos_z == (norm_z >>> 1)
      && vertex_index == '0 && !last)
    else $error("vertex record position does not match normal");

  a_index_clean: assert property (@(posedge clk) disable iff (rst)
    mesh_valid && kind == usmg_pkg::KIND_INDEX |->
      pos_x == '0 && pos_y == '0 && pos_z == '0
      && norm_x == '0 && norm_y == '0 && norm_z == '0)
    else $error("index record carries vertex data");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !mesh_valid)
    else $error("mesh record valid right after reset");

endmodule

bind uv_sphere_mesh_generator_core usmg_checker u_usmg_checker (
  .clk          (clk),
  .rst          (rst),
  .mesh_valid   (mesh.valid),
  .mesh_ready   (mesh.ready),
  .kind         (mesh.kind),
  .pos_x        (mesh.pos_x),
  .pos_y        (mesh.pos_y),
  .pos_z        (mesh.pos_z),
  .norm_x       (mesh.norm_x),
  .norm_y       (mesh.norm_y),
  .norm_z       (mesh.norm_z),
  .vertex_index (mesh.vertex_index),
  .last         (mesh.last)
);

`default_nettype wire
